[hw/rtl/gmuc_pkg.sv]
// shared constants, types and tables for the metric-vector to unit-cell converter
// depends on nothing; every other file of the block refers to it by scoped names
`default_nettype none

package gmuc_pkg;

  // fixed-point format of the metric vector
  localparam int FRAC_BITS = 16;
  localparam int IN_WIDTH  = 40;

  // widths of the result fields
  localparam int EDGE_W    = 28;
  localparam int ANG_OUT_W = 18;

  // root width covers both the edge roots and the sine root
  localparam int ROOT_W = ((IN_WIDTH + FRAC_BITS) > (2 * FRAC_BITS + 2)) ?
                          (IN_WIDTH + FRAC_BITS) / 2 : FRAC_BITS + 1;
  localparam int SQ_W   = 2 * ROOT_W;
  localparam int DEN_W  = 2 * ROOT_W;

  // cosine magnitude
  localparam int Q_W   = 2 * FRAC_BITS - 1;
  localparam int MAG_W = FRAC_BITS + 1;
  localparam int CAP   = (1 << FRAC_BITS) + 1;

  // cordic
  localparam int CORDIC_N = 24;
  localparam int XY_W     = 34;
  localparam int Z_W      = 28;
  localparam int XY_SH    = 30 - FRAC_BITS;

  localparam logic signed [Z_W-1:0] ATAN_Q24 [CORDIC_N] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
    28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
    28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
    28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
    28'sd256,      28'sd128,     28'sd64,      28'sd32,
    28'sd16,       28'sd8,       28'sd4,       28'sd2
  };

  localparam int PI_Q24   = 52707179;
  localparam int RND_SH   = 24 - FRAC_BITS;
  localparam int HALF_RND = (1 << RND_SH) >> 1;
  localparam int PI_Q     = (PI_Q24 + HALF_RND) >> RND_SH;
  localparam int TWO_PI_Q = (2 * PI_Q24 + HALF_RND) >> RND_SH;

  // internal angle and angle-sum widths
  localparam int ANG_W = FRAC_BITS + 2;
  localparam int SUM_W = ANG_W + 2;

  // pipeline depths
  localparam int ANG_LAT  = Q_W + ROOT_W + CORDIC_N + 5;
  localparam int PIPE_LAT = ROOT_W + ANG_LAT;

  // configuration port
  localparam int ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_DIAG_FLOOR = 2'd0,
    REG_COS_LIMIT  = 2'd1,
    REG_PART_FLOOR = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_DEGEN  = 2'd2,
    ST_GEOM   = 2'd3
  } status_e;

  // what one angle lane hands to the merge stage
  typedef struct packed {
    logic [ANG_W-1:0] ang;
    logic             degen;
  } lane_res_t;

  // one finished result
  typedef struct packed {
    logic [2:0][EDGE_W-1:0]    edges;
    logic [2:0][ANG_OUT_W-1:0] angs;
    logic                      cell_ok;
    status_e                   status;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/gram_metric_to_unit_cell.sv]
// throughput: one transaction per cycle; the whole pipeline advances together and holds
// while the output register is full and not taken
// reset: rst_ni asynchronous, active low; clears valid bits and loads the register defaults
// top level: G6 metric vector to unit cell; depends on gmuc_pkg, gmuc_sqrt,
// gmuc_angle_lane and gmuc_merge
`default_nettype none

module gram_metric_to_unit_cell (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [gmuc_pkg::ADDR_W-1:0]           paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  // input channel
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  src_ok_i,
  input  logic signed [gmuc_pkg::IN_WIDTH-1:0]  a_sq_i,
  input  logic signed [gmuc_pkg::IN_WIDTH-1:0]  b_sq_i,
  input  logic signed [gmuc_pkg::IN_WIDTH-1:0]  c_sq_i,
  input  logic signed [gmuc_pkg::IN_WIDTH-1:0]  two_bc_i,
  input  logic signed [gmuc_pkg::IN_WIDTH-1:0]  two_ac_i,
  input  logic signed [gmuc_pkg::IN_WIDTH-1:0]  two_ab_i,
  // output channel
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [gmuc_pkg::EDGE_W-1:0]           edge_a_o,
  output logic [gmuc_pkg::EDGE_W-1:0]           edge_b_o,
  output logic [gmuc_pkg::EDGE_W-1:0]           edge_c_o,
  output logic [gmuc_pkg::ANG_OUT_W-1:0]        angle_alpha_o,
  output logic [gmuc_pkg::ANG_OUT_W-1:0]        angle_beta_o,
  output logic [gmuc_pkg::ANG_OUT_W-1:0]        angle_gamma_o,
  output logic                                  cell_ok_o,
  output logic [1:0]                            status_o
);

  localparam int IW  = gmuc_pkg::IN_WIDTH;
  localparam int F   = gmuc_pkg::FRAC_BITS;
  localparam int RW  = gmuc_pkg::ROOT_W;
  localparam int SW  = gmuc_pkg::SQ_W;
  localparam int AL  = gmuc_pkg::ANG_LAT;
  localparam int PL  = gmuc_pkg::PIPE_LAT;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] diag_floor_q;
  logic [16:0] cos_limit_q;
  logic [15:0] part_floor_q;
  logic        cfg_wr;
  gmuc_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = gmuc_pkg::reg_idx_e'(paddr[gmuc_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diag_floor_q <= 16'd7;
      cos_limit_q  <= 17'd65529;
      part_floor_q <= 16'd7;
    end else if (cfg_wr) begin
      case (cfg_idx)
        gmuc_pkg::REG_DIAG_FLOOR: diag_floor_q <= pwdata[15:0];
        gmuc_pkg::REG_COS_LIMIT:  cos_limit_q  <= pwdata[16:0];
        gmuc_pkg::REG_PART_FLOOR: part_floor_q <= pwdata[15:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      gmuc_pkg::REG_DIAG_FLOOR: prdata = 32'(diag_floor_q);
      gmuc_pkg::REG_COS_LIMIT:  prdata = 32'(cos_limit_q);
      gmuc_pkg::REG_PART_FLOOR: prdata = 32'(part_floor_q);
      default:                  prdata = '0;
    endcase
  end

  // a cosine limit above one acts as one plus an lsb
  logic [gmuc_pkg::MAG_W-1:0] lim;
  assign lim = (32'(cos_limit_q) < 32'(gmuc_pkg::CAP)) ?
               gmuc_pkg::MAG_W'(cos_limit_q) : gmuc_pkg::MAG_W'(gmuc_pkg::CAP);

  // ---------------------------------------------------------------------------
  // flow control: one global advance, the output register parts the two sides
  // ---------------------------------------------------------------------------
  logic adv;
  logic out_valid_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // rejection is decided on the raw transaction and rides along to the end
  logic rej_in;
  assign rej_in = !src_ok_i ||
                  a_sq_i <= $signed(IW'(diag_floor_q)) ||
                  b_sq_i <= $signed(IW'(diag_floor_q)) ||
                  c_sq_i <= $signed(IW'(diag_floor_q));

  logic vld_q [PL];
  logic rej_q [PL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PL; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < PL; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rej_q[0] <= rej_in;
      for (int i = 1; i < PL; i++) begin
        rej_q[i] <= rej_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // edge lanes: square roots of the scaled diagonal
  // ---------------------------------------------------------------------------
  logic [2:0][SW-1:0] edge_rad;
  logic [2:0][RW-1:0] edge_root;

  // only meaningful for positive diagonals; rejected items carry garbage
  assign edge_rad[0] = SW'({a_sq_i[IW-2:0], {F{1'b0}}});
  assign edge_rad[1] = SW'({b_sq_i[IW-2:0], {F{1'b0}}});
  assign edge_rad[2] = SW'({c_sq_i[IW-2:0], {F{1'b0}}});

  for (genvar l = 0; l < 3; l++) begin : g_edge
    gmuc_sqrt u_edge (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rad_i  (edge_rad[l]),
      .root_o (edge_root[l])
    );
  end

  // dot products wait for the edges
  logic signed [IW-1:0] dot_q [3][RW];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dot_q[0][0] <= two_bc_i;
      dot_q[1][0] <= two_ac_i;
      dot_q[2][0] <= two_ab_i;
      for (int l = 0; l < 3; l++) begin
        for (int i = 1; i < RW; i++) begin
          dot_q[l][i] <= dot_q[l][i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // angle lanes: alpha from b and c, beta from a and c, gamma from a and b
  // ---------------------------------------------------------------------------
  gmuc_pkg::lane_res_t [2:0] lane_res;

  gmuc_angle_lane u_alpha (
    .clk_i (clk_i),
    .en_i  (adv),
    .dot_i (dot_q[0][RW-1]),
    .e1_i  (edge_root[1]),
    .e2_i  (edge_root[2]),
    .lim_i (lim),
    .res_o (lane_res[0])
  );

  gmuc_angle_lane u_beta (
    .clk_i (clk_i),
    .en_i  (adv),
    .dot_i (dot_q[1][RW-1]),
    .e1_i  (edge_root[0]),
    .e2_i  (edge_root[2]),
    .lim_i (lim),
    .res_o (lane_res[1])
  );

  gmuc_angle_lane u_gamma (
    .clk_i (clk_i),
    .en_i  (adv),
    .dot_i (dot_q[2][RW-1]),
    .e1_i  (edge_root[0]),
    .e2_i  (edge_root[1]),
    .lim_i (lim),
    .res_o (lane_res[2])
  );

  // edges wait for the angle lanes
  logic [2:0][RW-1:0] edge_dl_q [AL];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      edge_dl_q[0] <= edge_root;
      for (int i = 1; i < AL; i++) begin
        edge_dl_q[i] <= edge_dl_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // merge and output register
  // ---------------------------------------------------------------------------
  gmuc_pkg::res_t res;
  gmuc_pkg::res_t res_q;

  gmuc_merge u_merge (
    .rej_i        (rej_q[PL-1]),
    .edges_i      (edge_dl_q[AL-1]),
    .lanes_i      (lane_res),
    .part_floor_i (part_floor_q),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld_q[PL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign edge_a_o      = res_q.edges[0];
  assign edge_b_o      = res_q.edges[1];
  assign edge_c_o      = res_q.edges[2];
  assign angle_alpha_o = res_q.angs[0];
  assign angle_beta_o  = res_q.angs[1];
  assign angle_gamma_o = res_q.angs[2];
  assign cell_ok_o     = res_q.cell_ok;
  assign status_o      = res_q.status;

endmodule

`default_nettype wire

[hw/rtl/gmuc_sqrt.sv]
// pipelined integer square root, one result bit per stage
// depends on gmuc_pkg for widths
`default_nettype none

module gmuc_sqrt (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [gmuc_pkg::SQ_W-1:0]     rad_i,
  output logic [gmuc_pkg::ROOT_W-1:0]   root_o
);

  localparam int RW = gmuc_pkg::ROOT_W;
  localparam int SW = gmuc_pkg::SQ_W;

  logic [RW+1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [SW-1:0] rad_q  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+1:0] rem_in;
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    logic [RW-1:0] root_in;
    logic [SW-1:0] rad_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    // bring down the next two radicand bits
    assign rem_sh = {rem_in[RW-1:0], rad_in[SW-1 -: 2]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_sh >= trial) begin
          rem_q[k]  <= rem_sh - trial;
          root_q[k] <= {root_in[RW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_sh;
          root_q[k] <= {root_in[RW-2:0], 1'b0};
        end
        rad_q[k] <= {rad_in[SW-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule

`default_nettype wire

[hw/rtl/gmuc_angle_lane.sv]
// one angle lane: cosine magnitude by restoring division, sine by square root,
// arccosine by cordic vectoring; depends on gmuc_pkg and gmuc_sqrt
`default_nettype none

module gmuc_angle_lane (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [gmuc_pkg::IN_WIDTH-1:0] dot_i,
  input  logic [gmuc_pkg::ROOT_W-1:0]         e1_i,
  input  logic [gmuc_pkg::ROOT_W-1:0]         e2_i,
  input  logic [gmuc_pkg::MAG_W-1:0]          lim_i,
  output gmuc_pkg::lane_res_t                 res_o
);

  localparam int IW  = gmuc_pkg::IN_WIDTH;
  localparam int RW  = gmuc_pkg::ROOT_W;
  localparam int DW  = gmuc_pkg::DEN_W;
  localparam int QW  = gmuc_pkg::Q_W;
  localparam int MW  = gmuc_pkg::MAG_W;
  localparam int SW  = gmuc_pkg::SQ_W;
  localparam int N   = gmuc_pkg::CORDIC_N;
  localparam int XW  = gmuc_pkg::XY_W;
  localparam int ZW  = gmuc_pkg::Z_W;
  localparam logic [SW-1:0] ONE2 = SW'(1) << (2 * gmuc_pkg::FRAC_BITS);

  // multiply stage
  logic [IW-1:0] num_d;
  logic [DW-1:0] den_d;
  logic [IW-1:0] num_m_q;
  logic [DW-1:0] den_m_q;
  logic          neg_m_q;

  assign num_d = dot_i[IW-1] ? (~dot_i + 1'b1) : dot_i;
  assign den_d = e1_i * e2_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_m_q <= num_d;
      den_m_q <= den_d;
      neg_m_q <= dot_i[IW-1];
    end
  end

  // saturation compare stage
  logic [DW-1:0] r_c_q;
  logic [DW-1:0] den_c_q;
  logic          big_c_q;
  logic          neg_c_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_c_q   <= DW'(num_m_q);
      den_c_q <= den_m_q;
      big_c_q <= DW'(num_m_q) >= den_m_q;
      neg_c_q <= neg_m_q;
    end
  end

  // restoring division, one quotient bit per stage
  logic [DW-1:0] r_q   [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] q_q   [QW];
  logic          big_q [QW];
  logic          neg_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DW-1:0] r_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] q_in;
    logic          big_in;
    logic          neg_in;
    logic [DW:0]   r2;

    if (k == 0) begin : g_first
      assign r_in   = r_c_q;
      assign den_in = den_c_q;
      assign q_in   = '0;
      assign big_in = big_c_q;
      assign neg_in = neg_c_q;
    end else begin : g_next
      assign r_in   = r_q[k-1];
      assign den_in = den_q[k-1];
      assign q_in   = q_q[k-1];
      assign big_in = big_q[k-1];
      assign neg_in = neg_q[k-1];
    end

    assign r2 = {r_in, 1'b0};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (r2 >= {1'b0, den_in}) begin
          r_q[k] <= DW'(r2 - {1'b0, den_in});
          q_q[k] <= {q_in[QW-2:0], 1'b1};
        end else begin
          r_q[k] <= r2[DW-1:0];
          q_q[k] <= {q_in[QW-2:0], 1'b0};
        end
        den_q[k] <= den_in;
        big_q[k] <= big_in;
        neg_q[k] <= neg_in;
      end
    end
  end

  // clamp, limit check and squaring
  logic [QW-1:0]   qf;
  logic [MW-1:0]   mag_d;
  logic [MW-1:0]   mag_s_q;
  logic [2*MW-1:0] msq_s_q;
  logic            neg_s_q;
  logic            degen_s_q;

  assign qf    = q_q[QW-1];
  assign mag_d = (big_q[QW-1] || qf > QW'(gmuc_pkg::CAP)) ? MW'(gmuc_pkg::CAP) : qf[MW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_s_q   <= mag_d;
      msq_s_q   <= mag_d * mag_d;
      neg_s_q   <= neg_q[QW-1];
      degen_s_q <= mag_d >= lim_i;
    end
  end

  // radicand of the sine
  logic [SW-1:0] rad_r_q;
  logic [MW-1:0] mag_r_q;
  logic          neg_r_q;
  logic          degen_r_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_r_q   <= ONE2 - SW'(msq_s_q);
      mag_r_q   <= mag_s_q;
      neg_r_q   <= neg_s_q;
      degen_r_q <= degen_s_q;
    end
  end

  logic [RW-1:0] sine;

  gmuc_sqrt u_sine (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .rad_i  (rad_r_q),
    .root_o (sine)
  );

  // side data rides along with the square root
  logic [MW-1:0] mag_dl_q   [RW];
  logic          neg_dl_q   [RW];
  logic          degen_dl_q [RW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_dl_q[0]   <= mag_r_q;
      neg_dl_q[0]   <= neg_r_q;
      degen_dl_q[0] <= degen_r_q;
      for (int i = 1; i < RW; i++) begin
        mag_dl_q[i]   <= mag_dl_q[i-1];
        neg_dl_q[i]   <= neg_dl_q[i-1];
        degen_dl_q[i] <= degen_dl_q[i-1];
      end
    end
  end

  // cordic vectoring, one micro-rotation per stage
  logic signed [XW-1:0] x_q     [N];
  logic signed [XW-1:0] y_q     [N];
  logic signed [ZW-1:0] z_q     [N];
  logic                 neg_k_q [N];
  logic                 dgn_k_q [N];

  for (genvar k = 0; k < N; k++) begin : g_cordic
    localparam logic signed [XW-1:0] RND_MSK = XW'((64'd1 << k) - 64'd1);
    logic signed [XW-1:0] x_in;
    logic signed [XW-1:0] y_in;
    logic signed [ZW-1:0] z_in;
    logic                 neg_in;
    logic                 dgn_in;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;

    if (k == 0) begin : g_first
      assign x_in   = $signed(XW'(mag_dl_q[RW-1])) <<< gmuc_pkg::XY_SH;
      assign y_in   = $signed(XW'(sine)) <<< gmuc_pkg::XY_SH;
      assign z_in   = '0;
      assign neg_in = neg_dl_q[RW-1];
      assign dgn_in = degen_dl_q[RW-1];
    end else begin : g_next
      assign x_in   = x_q[k-1];
      assign y_in   = y_q[k-1];
      assign z_in   = z_q[k-1];
      assign neg_in = neg_k_q[k-1];
      assign dgn_in = dgn_k_q[k-1];
    end

    // shifts truncate toward zero; x never goes negative
    assign dx = y_in[XW-1] ? ((y_in + RND_MSK) >>> k) : (y_in >>> k);
    assign dy = x_in >>> k;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_in[XW-1]) begin
          x_q[k] <= x_in + dx;
          y_q[k] <= y_in - dy;
          z_q[k] <= z_in + gmuc_pkg::ATAN_Q24[k];
        end else begin
          x_q[k] <= x_in - dx;
          y_q[k] <= y_in + dy;
          z_q[k] <= z_in - gmuc_pkg::ATAN_Q24[k];
        end
        neg_k_q[k] <= neg_in;
        dgn_k_q[k] <= dgn_in;
      end
    end
  end

  // fold negative cosines, clamp and round to the output format
  logic signed [ZW-1:0] z_fold;
  logic signed [ZW-1:0] z_clmp;
  logic        [ZW-1:0] z_rnd;
  gmuc_pkg::lane_res_t  res_q;

  assign z_fold = neg_k_q[N-1] ? (ZW'(gmuc_pkg::PI_Q24) - z_q[N-1]) : z_q[N-1];
  assign z_clmp = z_fold[ZW-1] ? '0 : z_fold;
  assign z_rnd  = ($unsigned(z_clmp) + ZW'(gmuc_pkg::HALF_RND)) >> gmuc_pkg::RND_SH;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.ang   <= z_rnd[gmuc_pkg::ANG_W-1:0];
      res_q.degen <= dgn_k_q[N-1];
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

[hw/rtl/gmuc_merge.sv]
// merge stage: combines edges a, b and c and the alpha, beta and gamma angle lanes into status and result
// depends on gmuc_pkg for widths, status codes and the result type
`default_nettype none

module gmuc_merge (
  input  logic                                  rej_i,
  input  logic [2:0][gmuc_pkg::ROOT_W-1:0]      edges_i,
  input  gmuc_pkg::lane_res_t [2:0]             lanes_i,
  input  logic [15:0]                           part_floor_i,
  output gmuc_pkg::res_t                        res_o
);

  localparam int SMW = gmuc_pkg::SUM_W;
  localparam int AW  = gmuc_pkg::ANG_W;

  logic           part_ok;
  logic           degen;
  logic [AW-1:0]  mx;
  logic [SMW-1:0] sum;
  logic           geom_ok;

  always_comb begin
    part_ok = 1'b1;
    degen   = 1'b0;
    mx      = '0;
    for (int i = 0; i < 3; i++) begin
      if (edges_i[i] <= gmuc_pkg::ROOT_W'(part_floor_i) ||
          lanes_i[i].ang <= AW'(part_floor_i) ||
          lanes_i[i].ang >= AW'(gmuc_pkg::PI_Q)) begin
        part_ok = 1'b0;
      end
      if (lanes_i[i].degen) begin
        degen = 1'b1;
      end
      if (lanes_i[i].ang > mx) begin
        mx = lanes_i[i].ang;
      end
    end
  end

  assign sum = SMW'(lanes_i[0].ang) + SMW'(lanes_i[1].ang) + SMW'(lanes_i[2].ang);
  assign geom_ok = part_ok && (sum < SMW'(gmuc_pkg::TWO_PI_Q)) && (sum >= SMW'({mx, 1'b0}));

  always_comb begin
    res_o = '0;
    if (rej_i) begin
      res_o.status = gmuc_pkg::ST_REJECT;
    end else if (degen) begin
      res_o.status = gmuc_pkg::ST_DEGEN;
    end else begin
      for (int i = 0; i < 3; i++) begin
        res_o.edges[i] = gmuc_pkg::EDGE_W'(edges_i[i]);
        res_o.angs[i]  = gmuc_pkg::ANG_OUT_W'(lanes_i[i].ang);
      end
      res_o.cell_ok = geom_ok;
      res_o.status  = geom_ok ? gmuc_pkg::ST_OK : gmuc_pkg::ST_GEOM;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/gmuc_checker.sv]
// port-level checks for the metric-vector to unit-cell converter
// depends on gmuc_pkg; bound to gram_metric_to_unit_cell at the end of this file
`default_nettype none

module gmuc_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_ready_o,
  input  logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  input  logic [gmuc_pkg::EDGE_W-1:0]           edge_a_o,
  input  logic [gmuc_pkg::EDGE_W-1:0]           edge_b_o,
  input  logic [gmuc_pkg::EDGE_W-1:0]           edge_c_o,
  input  logic [gmuc_pkg::ANG_OUT_W-1:0]        angle_alpha_o,
  input  logic [gmuc_pkg::ANG_OUT_W-1:0]        angle_beta_o,
  input  logic [gmuc_pkg::ANG_OUT_W-1:0]        angle_gamma_o,
  input  logic                                  cell_ok_o,
  input  logic [1:0]                            status_o
);

  // a pending output transaction stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  // the input side only stalls behind a full, untaken output register
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input stalled with room at the output");

  // cell_ok and status agree
  a_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cell_ok_o == (status_o == gmuc_pkg::ST_OK)))
    else $error("cell_ok disagrees with status");

  // rejected and degenerate transactions carry all-zero fields
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == gmuc_pkg::ST_REJECT || status_o == gmuc_pkg::ST_DEGEN)
    |-> (edge_a_o == '0 && edge_b_o == '0 && edge_c_o == '0 &&
         angle_alpha_o == '0 && angle_beta_o == '0 && angle_gamma_o == '0))
    else $error("nonzero fields on a rejected transaction");

endmodule

bind gram_metric_to_unit_cell gmuc_checker u_gmuc_checker (.*);

`default_nettype wire
